// File: sv/idhsl_pkg.sv
// shared types, constants and arithmetic helpers of the id hash to color block
`default_nettype none

package idhsl_pkg;

  // fraction format of the color arithmetic
  localparam int FRAC_BITS = 16;

  // crc-32 reflected polynomial and preset
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

  // one third of a full hue turn, truncated
  localparam logic [15:0] HUE_THIRD = 16'((1 << FRAC_BITS) / 3);

  // configuration register indexes
  localparam logic [2:0] REG_HUE_CENTER = 3'd0;
  localparam logic [2:0] REG_HUE_SPAN   = 3'd1;
  localparam logic [2:0] REG_SAT_MIN    = 3'd2;
  localparam logic [2:0] REG_SAT_MAX    = 3'd3;
  localparam logic [2:0] REG_LIGHT_MIN  = 3'd4;
  localparam logic [2:0] REG_LIGHT_MAX  = 3'd5;

  // configuration reset values
  localparam logic [15:0] RST_HUE_CENTER = 16'd45875;
  localparam logic [15:0] RST_HUE_SPAN   = 16'd11796;
  localparam logic [15:0] RST_SAT_MIN    = 16'd36045;
  localparam logic [15:0] RST_SAT_MAX    = 16'd55706;
  localparam logic [15:0] RST_LIGHT_MIN  = 16'd40632;
  localparam logic [15:0] RST_LIGHT_MAX  = 16'd49807;

  // datapath step issued by the controller
  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_HUE_MUL,
    STEP_SAT_MUL,
    STEP_LIT_MUL,
    STEP_LIT_TAKE,
    STEP_LS_MUL,
    STEP_Q_TAKE,
    STEP_PD,
    STEP_R_MUL,
    STEP_G_MUL,
    STEP_B_MUL,
    STEP_B_TAKE,
    STEP_OUT
  } dp_step_e;

  // controller to datapath command
  typedef struct packed {
    logic     take_item;
    dp_step_e step;
    logic     out_load;
  } dp_cmd_t;

  // piece of the hls hue ramp a channel falls on
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_TOP,
    SEG_FALL,
    SEG_BASE
  } hue_seg_e;

  typedef struct packed {
    hue_seg_e    seg;
    logic [16:0] slope;
  } hue_seg_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ {1'b0, c[31:1]}) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  // sel * 2^16 / 4095, truncated: 16*sel plus the small quotient (2^12-1 trick)
  function automatic logic [16:0] sel12_to_frac(input logic [11:0] sel);
    logic [15:0] y;
    logic [16:0] acc;
    y   = {sel, 4'b0};
    acc = {1'b0, y} + {13'd0, y[15:12]} + 17'd1;
    return {1'b0, y} + {12'd0, acc[16:12]};
  endfunction

  // sel * 2^16 / 1023, truncated: 64*sel plus the small quotient (2^10-1 trick)
  function automatic logic [16:0] sel10_to_frac(input logic [9:0] sel);
    logic [15:0] y;
    logic [16:0] acc;
    y   = {sel, 6'b0};
    acc = {1'b0, y} + {11'd0, y[15:10]} + 17'd1;
    return {1'b0, y} + {10'd0, acc[16:10]};
  endfunction

  // ramp segment and multiplier slope for a channel hue position
  function automatic hue_seg_t hue_segment(input logic [15:0] t);
    logic [18:0] t6;
    logic [17:0] t3;
    logic [18:0] fall;
    hue_seg_t    res;
    t3   = {2'b0, t} + {1'b0, t, 1'b0};
    t6   = {t3, 1'b0};
    fall = 19'd262144 - t6;
    if (t6 < 19'd65536) begin
      res.seg   = SEG_RISE;
      res.slope = t6[16:0];
    end else if (!t[15]) begin
      res.seg   = SEG_TOP;
      res.slope = 17'd0;
    end else if (t3 < 18'd131072) begin
      res.seg   = SEG_FALL;
      res.slope = fall[16:0];
    end else begin
      res.seg   = SEG_BASE;
      res.slope = 17'd0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/idhsl_ctrl.sv
// controller of the id hash to color block: handshakes and color step sequence
`default_nettype none

module idhsl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic              s_tlast_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output idhsl_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HUE,
    ST_SAT,
    ST_LIT,
    ST_LIT_TAKE,
    ST_LS,
    ST_Q_TAKE,
    ST_PD,
    ST_R,
    ST_G,
    ST_B,
    ST_B_TAKE,
    ST_OUT
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;
  logic        load;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign accept     = s_tvalid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || m_tready_i;
  assign load       = (state_q == ST_OUT) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept && s_tlast_i) state_d = ST_HUE;
      ST_HUE:      state_d = ST_SAT;
      ST_SAT:      state_d = ST_LIT;
      ST_LIT:      state_d = ST_LIT_TAKE;
      ST_LIT_TAKE: state_d = ST_LS;
      ST_LS:       state_d = ST_Q_TAKE;
      ST_Q_TAKE:   state_d = ST_PD;
      ST_PD:       state_d = ST_R;
      ST_R:        state_d = ST_G;
      ST_G:        state_d = ST_B;
      ST_B:        state_d = ST_B_TAKE;
      ST_B_TAKE:   state_d = ST_OUT;
      ST_OUT:      if (load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // result register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // datapath command
  always_comb begin
    cmd_o.take_item = accept;
    cmd_o.out_load  = load;
    unique case (state_q)
      ST_IDLE:     cmd_o.step = idhsl_pkg::STEP_IDLE;
      ST_HUE:      cmd_o.step = idhsl_pkg::STEP_HUE_MUL;
      ST_SAT:      cmd_o.step = idhsl_pkg::STEP_SAT_MUL;
      ST_LIT:      cmd_o.step = idhsl_pkg::STEP_LIT_MUL;
      ST_LIT_TAKE: cmd_o.step = idhsl_pkg::STEP_LIT_TAKE;
      ST_LS:       cmd_o.step = idhsl_pkg::STEP_LS_MUL;
      ST_Q_TAKE:   cmd_o.step = idhsl_pkg::STEP_Q_TAKE;
      ST_PD:       cmd_o.step = idhsl_pkg::STEP_PD;
      ST_R:        cmd_o.step = idhsl_pkg::STEP_R_MUL;
      ST_G:        cmd_o.step = idhsl_pkg::STEP_G_MUL;
      ST_B:        cmd_o.step = idhsl_pkg::STEP_B_MUL;
      ST_B_TAKE:   cmd_o.step = idhsl_pkg::STEP_B_TAKE;
      ST_OUT:      cmd_o.step = idhsl_pkg::STEP_OUT;
      default:     cmd_o.step = idhsl_pkg::STEP_IDLE;
    endcase
  end

  // state and output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/idhsl_dp.sv
// datapath of the id hash to color block: crc, config registers, shared multiplier
`default_nettype none

module idhsl_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire idhsl_pkg::dp_cmd_t cmd_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               in_no_byte_i,
  input  wire logic               in_last_i,
  output logic [79:0]             out_data_o
);

  // configuration registers
  logic [15:0] hue_center_q, hue_span_q, sat_min_q, sat_max_q, light_min_q, light_max_q;

  // hash state
  logic [31:0] crc_q, crc_next, seed_q;

  // color working registers
  logic [17:0] prod_q;
  logic [15:0] h_q, s_q, l_q, r_q, g_q, b_q;
  logic [16:0] q_q, p_q, d_q;
  logic [79:0] out_data_q;

  // combinational helpers
  logic [16:0] hf, sf, lf;
  logic        sat_up, light_up;
  logic [15:0] sat_diff, light_diff;
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_full;
  logic [15:0] t_r, t_b;
  idhsl_pkg::hue_seg_t seg_r, seg_g, seg_b, seg_take;
  logic [17:0] chan_raw;
  logic [15:0] chan_val;
  logic [16:0] two_l, p_d, d_d;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_center_q <= idhsl_pkg::RST_HUE_CENTER;
      hue_span_q   <= idhsl_pkg::RST_HUE_SPAN;
      sat_min_q    <= idhsl_pkg::RST_SAT_MIN;
      sat_max_q    <= idhsl_pkg::RST_SAT_MAX;
      light_min_q  <= idhsl_pkg::RST_LIGHT_MIN;
      light_max_q  <= idhsl_pkg::RST_LIGHT_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        idhsl_pkg::REG_HUE_CENTER: hue_center_q <= cfg_wdata_i;
        idhsl_pkg::REG_HUE_SPAN:   hue_span_q   <= cfg_wdata_i;
        idhsl_pkg::REG_SAT_MIN:    sat_min_q    <= cfg_wdata_i;
        idhsl_pkg::REG_SAT_MAX:    sat_max_q    <= cfg_wdata_i;
        idhsl_pkg::REG_LIGHT_MIN:  light_min_q  <= cfg_wdata_i;
        idhsl_pkg::REG_LIGHT_MAX:  light_max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // crc update on every transfer that carries a byte
  assign crc_next = in_no_byte_i ? crc_q : idhsl_pkg::crc_byte(crc_q, in_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= idhsl_pkg::CRC_PRESET;
    end else if (cmd_i.take_item) begin
      crc_q <= in_last_i ? idhsl_pkg::CRC_PRESET : crc_next;
    end
  end

  // finished hash held for the color steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && in_last_i) begin
      seed_q <= crc_next ^ idhsl_pkg::CRC_PRESET;
    end
  end

  // selector fractions of the hash
  assign hf = idhsl_pkg::sel12_to_frac(seed_q[31:20]);
  assign sf = idhsl_pkg::sel10_to_frac(seed_q[19:10]);
  assign lf = idhsl_pkg::sel10_to_frac(seed_q[9:0]);

  // range direction and width
  assign sat_up     = (sat_max_q >= sat_min_q);
  assign sat_diff   = sat_up ? (sat_max_q - sat_min_q) : (sat_min_q - sat_max_q);
  assign light_up   = (light_max_q >= light_min_q);
  assign light_diff = light_up ? (light_max_q - light_min_q) : (light_min_q - light_max_q);

  // channel hue positions and their ramp segments
  assign t_r   = h_q + idhsl_pkg::HUE_THIRD;
  assign t_b   = h_q - idhsl_pkg::HUE_THIRD;
  assign seg_r = idhsl_pkg::hue_segment(t_r);
  assign seg_g = idhsl_pkg::hue_segment(h_q);
  assign seg_b = idhsl_pkg::hue_segment(t_b);

  // shared multiplier operands
  always_comb begin
    case (cmd_i.step)
      idhsl_pkg::STEP_HUE_MUL: begin
        mul_a = hf;
        mul_b = {1'b0, hue_span_q};
      end
      idhsl_pkg::STEP_SAT_MUL: begin
        mul_a = sf;
        mul_b = {1'b0, sat_diff};
      end
      idhsl_pkg::STEP_LIT_MUL: begin
        mul_a = lf;
        mul_b = {1'b0, light_diff};
      end
      idhsl_pkg::STEP_LS_MUL: begin
        mul_a = {1'b0, l_q};
        mul_b = {1'b0, s_q};
      end
      idhsl_pkg::STEP_R_MUL: begin
        mul_a = d_q;
        mul_b = seg_r.slope;
      end
      idhsl_pkg::STEP_G_MUL: begin
        mul_a = d_q;
        mul_b = seg_g.slope;
      end
      idhsl_pkg::STEP_B_MUL: begin
        mul_a = d_q;
        mul_b = seg_b.slope;
      end
      default: begin
        mul_a = 17'd0;
        mul_b = 17'd0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // channel value from the product of the previous step
  always_comb begin
    case (cmd_i.step)
      idhsl_pkg::STEP_G_MUL: seg_take = seg_r;
      idhsl_pkg::STEP_B_MUL: seg_take = seg_g;
      default:               seg_take = seg_b;
    endcase
    case (seg_take.seg) inside
      idhsl_pkg::SEG_RISE, idhsl_pkg::SEG_FALL: chan_raw = {1'b0, p_q} + prod_q;
      idhsl_pkg::SEG_TOP:                       chan_raw = {1'b0, q_q};
      default:                                  chan_raw = {1'b0, p_q};
    endcase
    if (s_q == 16'd0) begin
      chan_val = l_q;
    end else if (chan_raw > 18'd65535) begin
      chan_val = 16'hFFFF;
    end else begin
      chan_val = chan_raw[15:0];
    end
  end

  // p clamps at zero, and so does q - p
  assign two_l = {l_q, 1'b0};
  assign p_d   = (two_l >= q_q) ? (two_l - q_q) : 17'd0;
  assign d_d   = (q_q > p_d) ? (q_q - p_d) : 17'd0;

  // color working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[33:16];
    case (cmd_i.step)
      idhsl_pkg::STEP_SAT_MUL: begin
        h_q <= hue_center_q + prod_q[15:0] - {1'b0, hue_span_q[15:1]};
      end
      idhsl_pkg::STEP_LIT_MUL: begin
        s_q <= sat_up ? (sat_min_q + prod_q[15:0]) : (sat_min_q - prod_q[15:0]);
      end
      idhsl_pkg::STEP_LIT_TAKE: begin
        l_q <= light_up ? (light_min_q + prod_q[15:0]) : (light_min_q - prod_q[15:0]);
      end
      idhsl_pkg::STEP_Q_TAKE: begin
        if (!l_q[15]) begin
          q_q <= {1'b0, l_q} + {1'b0, prod_q[15:0]};
        end else begin
          q_q <= {1'b0, l_q} + {1'b0, s_q} - {1'b0, prod_q[15:0]};
        end
      end
      idhsl_pkg::STEP_PD: begin
        p_q <= p_d;
        d_q <= d_d;
      end
      idhsl_pkg::STEP_G_MUL: r_q <= chan_val;
      idhsl_pkg::STEP_B_MUL: g_q <= chan_val;
      idhsl_pkg::STEP_B_TAKE: b_q <= chan_val;
      default: ;
    endcase
    // the result register changes only when it is free
    if (cmd_i.out_load) begin
      out_data_q <= {b_q, g_q, r_q, seed_q};
    end
  end

  assign out_data_o = out_data_q;

endmodule

`default_nettype wire

// File: sv/id_hash_to_hsl_color_top.sv
// top level of the id hash to color block
// Identifier bytes arrive on the s_axis stream, one byte per transfer:
// tdata carries the byte, tuser marks a transfer without a byte (only
// meaningful with tlast, for an empty identifier) and tlast closes the id.
// Each byte is folded into a reflected CRC-32 in the cycle it is taken.
// On the tlast transfer the finished hash is latched, the CRC preset again,
// and the color is worked out over eleven steps through one shared 17x17
// multiplier (hue, saturation, lightness, l*s, then one ramp product per
// channel). The result goes out on m_axis as hash and red, green, blue.
// Throughput: one byte per cycle within an identifier; after a tlast
// transfer the input stays not ready while the color steps run and until
// the output register takes the result; m_axis tvalid then rises.
// The result sits in an output register; if the receiver stalls, bytes of
// the next identifier are still taken, and only its final load step waits
// for the register to be freed. The cfg port has no read-back; the user
// must write configuration only while idle; the block does not check it.
// Reset clears the CRC to all ones, empties the output register and loads
// the default color ranges.
`default_nettype none

module id_hash_to_hsl_color_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] id_byte
  input  wire logic        s_axis_tuser,   // [0] no_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // [31:0] hash_value, [47:32] red,
                                           // [63:48] green, [79:64] blue
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  idhsl_pkg::dp_cmd_t cmd;

  // sequencing and handshakes
  idhsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  // hash and color arithmetic
  idhsl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .in_byte_i    (s_axis_tdata),
    .in_no_byte_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .out_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: test/tb_id_hash_to_hsl_color_top.sv
`timescale 1ns / 100ps
// testbench of the id hash to color block: random identifiers checked against a color predictor

module tb_id_hash_to_hsl_color_top;

  localparam int ITEM_TARGET = 1700;
  localparam int PHASE_ITEMS = 190;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  // indexes past the register file, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam longint unsigned FX_ONE = 64'd65536;
  localparam longint unsigned FX_THIRD = FX_ONE / 3;

  typedef struct {
    logic [31:0] hash;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } id_color_t;

  // running crc, color ranges and the colors still owed by the block
  class color_scoreboard;
    logic [31:0] crc;
    logic [15:0] regs [6];
    id_color_t   awaited_colors [$];
    int          errors;

    function new();
      crc     = idhsl_pkg::CRC_PRESET;
      regs[0] = idhsl_pkg::RST_HUE_CENTER;
      regs[1] = idhsl_pkg::RST_HUE_SPAN;
      regs[2] = idhsl_pkg::RST_SAT_MIN;
      regs[3] = idhsl_pkg::RST_SAT_MAX;
      regs[4] = idhsl_pkg::RST_LIGHT_MIN;
      regs[5] = idhsl_pkg::RST_LIGHT_MAX;
      errors  = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      if (idx <= idhsl_pkg::REG_LIGHT_MAX) regs[idx] = val;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // value placed inside a range that may run backwards
    function longint unsigned spread(longint unsigned frac, longint unsigned lo,
                                     longint unsigned hi);
      if (hi >= lo) return lo + ((frac * (hi - lo)) >> 16);
      return lo - ((frac * (lo - hi)) >> 16);
    endfunction

    // one channel of the hls ramp at hue position t
    function longint unsigned ramp(longint unsigned p, longint unsigned q,
                                   longint unsigned t);
      longint unsigned d;
      d = (q > p) ? q - p : 0;
      if (6 * t < FX_ONE) return p + ((d * 6 * t) >> 16);
      if (2 * t < FX_ONE) return q;
      if (3 * t < 2 * FX_ONE) return p + ((d * (4 * FX_ONE - 6 * t)) >> 16);
      return p;
    endfunction

    function logic [15:0] to_out(longint unsigned x);
      return (x > 65535) ? 16'hFFFF : x[15:0];
    endfunction

    function id_color_t predict_color(logic [31:0] seed);
      id_color_t       res;
      longint unsigned hf, sf, lf, span, h, s, l, q, p, r, g, b;
      longint          ps;
      hf   = (longint'(seed[31:20]) * FX_ONE) / 4095;
      sf   = (longint'(seed[19:10]) * FX_ONE) / 1023;
      lf   = (longint'(seed[9:0]) * FX_ONE) / 1023;
      span = regs[idhsl_pkg::REG_HUE_SPAN];
      h    = (regs[idhsl_pkg::REG_HUE_CENTER] + FX_ONE + ((hf * span) >> 16) - (span >> 1))
             & 16'hFFFF;
      s    = spread(sf, regs[idhsl_pkg::REG_SAT_MIN], regs[idhsl_pkg::REG_SAT_MAX]);
      l    = spread(lf, regs[idhsl_pkg::REG_LIGHT_MIN], regs[idhsl_pkg::REG_LIGHT_MAX]);
      if (s == 0) begin
        r = l;
        g = l;
        b = l;
      end else begin
        if (2 * l < FX_ONE) q = (l * (FX_ONE + s)) >> 16;
        else q = l + s - ((l * s) >> 16);
        ps = longint'(2 * l) - longint'(q);
        p  = (ps < 0) ? 0 : ps;
        r  = ramp(p, q, (h + FX_THIRD) & 16'hFFFF);
        g  = ramp(p, q, h);
        b  = ramp(p, q, (h + FX_ONE - FX_THIRD) & 16'hFFFF);
      end
      res.hash  = seed;
      res.red   = to_out(r);
      res.green = to_out(g);
      res.blue  = to_out(b);
      return res;
    endfunction

    // fold an accepted transfer into the crc, close the id on last
    function void note_item(logic [7:0] data, logic no_byte, logic last);
      logic [31:0] c;
      if (!no_byte) begin
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
          c = c[0] ? ((c >> 1) ^ idhsl_pkg::CRC_POLY) : (c >> 1);
        end
        crc = c;
      end
      if (last) begin
        awaited_colors.insert(awaited_colors.size(),
                              predict_color(crc ^ idhsl_pkg::CRC_PRESET));
        crc = idhsl_pkg::CRC_PRESET;
      end
    endfunction

    task check_result(logic [79:0] data);
      id_color_t want;
      if (awaited_colors.size() == 0) begin
        report($sformatf("result %h with nothing expected", data));
      end else begin
        want = awaited_colors.pop_front();
        if (data[31:0] !== want.hash)
          report($sformatf("hash %h, expected %h", data[31:0], want.hash));
        if (data[47:32] !== want.red)
          report($sformatf("red %h, expected %h (hash %h)", data[47:32], want.red, want.hash));
        if (data[63:48] !== want.green)
          report($sformatf("green %h, expected %h (hash %h)", data[63:48], want.green,
                           want.hash));
        if (data[79:64] !== want.blue)
          report($sformatf("blue %h, expected %h (hash %h)", data[79:64], want.blue,
                           want.hash));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] id_byte
  logic        s_axis_tuser = 1'b0;   // [0] no_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;          // [31:0] hash_value, [47:32] red, [63:48] green,
                                      // [79:64] blue
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = 3'd0;
  logic [15:0] cfg_wdata_i = 16'd0;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  color_scoreboard sb = new();

  id_hash_to_hsl_color_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // transfers seen at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // result receiver: random stalls plus the long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // offer one byte transfer, return at the falling edge after it is taken
  task automatic send_item(input logic [7:0] data, input logic no_byte, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tuser  = no_byte;
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (!no_byte || last) items_sent++;
  endtask

  // one identifier with random bytes, stray empty transfers and varied endings
  task automatic send_random_id();
    int r;
    int len;
    bit empty_end;
    r = $urandom_range(0, 99);
    len = (r < 8) ? 0 : (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    empty_end = ($urandom_range(0, 99) < 15);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b0, (i == len - 1) && !empty_end);
    end
    if (len == 0 || empty_end) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // stop offering and let every owed color come out
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.awaited_colors.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_colors(input logic [15:0] center, input logic [15:0] span,
                            input logic [15:0] s_lo, input logic [15:0] s_hi,
                            input logic [15:0] l_lo, input logic [15:0] l_hi);
    write_cfg(idhsl_pkg::REG_HUE_CENTER, center);
    write_cfg(idhsl_pkg::REG_HUE_SPAN, span);
    write_cfg(idhsl_pkg::REG_SAT_MIN, s_lo);
    write_cfg(idhsl_pkg::REG_SAT_MAX, s_hi);
    write_cfg(idhsl_pkg::REG_LIGHT_MIN, l_lo);
    write_cfg(idhsl_pkg::REG_LIGHT_MAX, l_hi);
  endtask

  function automatic logic [15:0] any16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // color ranges of each phase
  task automatic configure(input int phase);
    case (phase)
      1: set_colors(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      2: set_colors(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // ranges given backwards
      3: set_colors(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      // zero saturation
      4: set_colors(any16(), any16(), 16'h0000, 16'h0000, any16(), any16());
      // dark and vivid, plus writes beyond the register file
      5: begin
        set_colors(any16(), any16(), 16'($urandom_range(49152, 65535)), 16'hFFFF,
                   16'h0000, 16'($urandom_range(0, 24000)));
        write_cfg(REG_SPARE_LO, any16());
        write_cfg(REG_SPARE_HI, any16());
      end
      7: set_colors(idhsl_pkg::RST_HUE_CENTER, idhsl_pkg::RST_HUE_SPAN,
                    idhsl_pkg::RST_SAT_MIN, idhsl_pkg::RST_SAT_MAX,
                    idhsl_pkg::RST_LIGHT_MIN, idhsl_pkg::RST_LIGHT_MAX);
      default: set_colors(any16(), any16(), any16(), any16(), any16(), any16());
    endcase
  endtask

  initial begin
    int phase;
    int phase_end;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty id, extreme bytes, ignored empty transfer, check string,
    // id closed by an empty transfer
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h31, 1'b0, 1'b1);
    for (int k = 1; k <= 9; k++) send_item(8'h30 + 8'(k), 1'b0, k == 9);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h7F, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase > 0) begin
        drain();
        configure(phase);
      end
      quiet = (phase == 5 || phase == 6);
      // receiver holds off while ids keep coming, so the block backs up
      if (phase == 6) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_id();
      phase++;
    end
    quiet = 1'b0;
    drain();

    if (sb.errors == 0) begin
      $display("tb_id_hash_to_hsl_color_top: PASS");
    end else begin
      $display("tb_id_hash_to_hsl_color_top: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_id_hash_to_hsl_color_top: FAIL");
    $finish;
  end

endmodule
